### rtl/core/kcl_pkg.sv
// Package for the keypad code lock: key and field widths, code lengths,
// verdict, echo and register index codes, and reset values of the registers.
// No dependencies.
package kcl_pkg;

  localparam int CODE_KEYS      = 6;
  localparam int EMERGENCY_KEYS = 3;

  localparam int KEY_W     = 4;
  localparam int POS_W     = 3;
  localparam int ATTEMPT_W = 3;
  localparam int PASS_W    = 24;
  localparam int EMERG_W   = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = PASS_W;
  localparam int S_DATA_W  = 8;
  localparam int M_DATA_W  = 16;

  localparam logic [POS_W-1:0] CODE_LAST  = POS_W'(CODE_KEYS - 1);
  localparam logic [POS_W-1:0] EMERG_LAST = POS_W'(EMERGENCY_KEYS - 1);

  localparam logic [PASS_W-1:0]    PASS_RESET  = 24'h123321;
  localparam logic [EMERG_W-1:0]   EMERG_RESET = 12'h222;
  localparam logic [ATTEMPT_W-1:0] MAX_RESET   = 3'd3;

  typedef enum logic [1:0] {
    ECHO_KEY   = 2'd0,
    ECHO_ERROR = 2'd1,
    ECHO_MASK  = 2'd2
  } echo_t;

  typedef enum logic [2:0] {
    VERDICT_BUSY        = 3'd0,
    VERDICT_OPEN        = 3'd1,
    VERDICT_WRONG       = 3'd2,
    VERDICT_BLOCKED     = 3'd3,
    VERDICT_UNBLOCKED   = 3'd4,
    VERDICT_EMERG_WRONG = 3'd5
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PASS_CODE    = 2'd0,
    REG_EMERG_CODE   = 2'd1,
    REG_MAX_ATTEMPTS = 2'd2
  } cfg_reg_t;

  // Key code at a given position of a code word; nibbles past the word read as zero.
  function automatic logic [KEY_W-1:0] code_nibble(input logic [31:0] word,
                                                   input logic [POS_W-1:0] pos);
    return word[{pos, 2'b00} +: KEY_W];
  endfunction

  // A zero grant is loaded as one attempt.
  function automatic logic [ATTEMPT_W-1:0] granted(input logic [ATTEMPT_W-1:0] max_att);
    return (max_att == '0) ? ATTEMPT_W'(1) : max_att;
  endfunction

endpackage

### rtl/core/keypad_code_lock_top.sv
// Keypad code lock: compares each key with the passcode or the emergency code
// and reports one result transaction per key transaction. Depends on kcl_pkg.
// The result of an accepted key is loaded into the output register at the next clock edge.
// Throughput: one key per cycle; a key is taken whenever the output register is
// empty or its result is taken in the same cycle.
// Reset (rst, synchronous): registers return to their reset codes, the lock to
// normal entry at the first key with three attempts, the output register empties.
module keypad_code_lock_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [kcl_pkg::S_DATA_W-1:0]  s_tdata,   // [3:0] key
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [kcl_pkg::M_DATA_W-1:0]  m_tdata,   // [1:0] echo, [5:2] shown_key,
                                                   // [8:6] verdict, [11:9] attempts_left,
                                                   // [12] blocked
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kcl_pkg::CFG_W-1:0]     cfg_data
);

  logic [kcl_pkg::PASS_W-1:0]    pass_code;
  logic [kcl_pkg::EMERG_W-1:0]   emergency_code;
  logic [kcl_pkg::ATTEMPT_W-1:0] max_attempts;

  logic                          blocked_mode, blocked_mode_next;
  logic [kcl_pkg::POS_W-1:0]     key_position, key_position_next;
  logic                          mismatch_seen, mismatch_seen_next;
  logic [kcl_pkg::ATTEMPT_W-1:0] attempts_remaining, attempts_remaining_next;

  kcl_pkg::echo_t                echo_r, echo_next;
  logic [kcl_pkg::KEY_W-1:0]     shown_key_r;
  kcl_pkg::verdict_t             verdict_r, verdict_next;
  logic [kcl_pkg::ATTEMPT_W-1:0] attempts_r;
  logic                          blocked_r;

  logic [kcl_pkg::KEY_W-1:0]     key;
  logic [kcl_pkg::KEY_W-1:0]     expected;
  logic                          mismatch;
  logic [kcl_pkg::ATTEMPT_W-1:0] attempts_dec;
  logic                          in_accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;
  assign key       = s_tdata[kcl_pkg::KEY_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_code      <= kcl_pkg::PASS_RESET;
      emergency_code <= kcl_pkg::EMERG_RESET;
      max_attempts   <= kcl_pkg::MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kcl_pkg::REG_PASS_CODE:    pass_code      <= cfg_data[kcl_pkg::PASS_W-1:0];
        kcl_pkg::REG_EMERG_CODE:   emergency_code <= cfg_data[kcl_pkg::EMERG_W-1:0];
        kcl_pkg::REG_MAX_ATTEMPTS: max_attempts   <= cfg_data[kcl_pkg::ATTEMPT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    blocked_mode_next       = blocked_mode;
    key_position_next       = key_position + kcl_pkg::POS_W'(1);
    mismatch_seen_next      = 1'b0;
    attempts_remaining_next = attempts_remaining;
    verdict_next            = kcl_pkg::VERDICT_BUSY;
    attempts_dec            = (attempts_remaining != '0)
                              ? attempts_remaining - kcl_pkg::ATTEMPT_W'(1)
                              : attempts_remaining;
    if (blocked_mode) begin
      expected = kcl_pkg::code_nibble(32'(emergency_code), key_position);
    end else begin
      expected = kcl_pkg::code_nibble(32'(pass_code), key_position);
    end
    mismatch = mismatch_seen || (key != expected);
    if (blocked_mode) begin
      echo_next = kcl_pkg::ECHO_MASK;
      if (key_position >= kcl_pkg::EMERG_LAST) begin
        key_position_next = '0;
        if (!mismatch) begin
          attempts_remaining_next = kcl_pkg::granted(max_attempts);
          blocked_mode_next       = 1'b0;
          verdict_next            = kcl_pkg::VERDICT_UNBLOCKED;
        end else begin
          verdict_next = kcl_pkg::VERDICT_EMERG_WRONG;
        end
      end else begin
        mismatch_seen_next = mismatch;
      end
    end else begin
      echo_next = mismatch ? kcl_pkg::ECHO_ERROR : kcl_pkg::ECHO_KEY;
      if (key_position >= kcl_pkg::CODE_LAST) begin
        key_position_next = '0;
        if (!mismatch) begin
          verdict_next = kcl_pkg::VERDICT_OPEN;
        end else begin
          attempts_remaining_next = attempts_dec;
          if (attempts_dec == '0) begin
            blocked_mode_next = 1'b1;
            verdict_next      = kcl_pkg::VERDICT_BLOCKED;
          end else begin
            verdict_next = kcl_pkg::VERDICT_WRONG;
          end
        end
      end else begin
        mismatch_seen_next = mismatch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blocked_mode       <= 1'b0;
      key_position       <= '0;
      mismatch_seen      <= 1'b0;
      attempts_remaining <= kcl_pkg::granted(kcl_pkg::MAX_RESET);
      m_tvalid           <= 1'b0;
    end else begin
      if (in_accept) begin
        blocked_mode       <= blocked_mode_next;
        key_position       <= key_position_next;
        mismatch_seen      <= mismatch_seen_next;
        attempts_remaining <= attempts_remaining_next;
        m_tvalid           <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      echo_r      <= echo_next;
      shown_key_r <= key;
      verdict_r   <= verdict_next;
      attempts_r  <= attempts_remaining_next;
      blocked_r   <= blocked_mode_next;
    end
  end

  assign m_tdata = {3'b000, blocked_r, attempts_r, verdict_r, shown_key_r, echo_r};

  a_pos_in_code: assert property (@(posedge clk) disable iff (rst)
    key_position <= kcl_pkg::CODE_LAST)
    else $error("key position ran past the passcode length");

  a_attempts_open: assert property (@(posedge clk) disable iff (rst)
    !blocked_mode |-> attempts_remaining != '0)
    else $error("normal entry with no attempts left");

  a_blocked_echo: assert property (@(posedge clk) disable iff (rst)
    in_accept && blocked_mode |=> echo_r == kcl_pkg::ECHO_MASK)
    else $error("blocked mode key not masked");

  a_block_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(blocked_mode) |-> m_tvalid && verdict_r == kcl_pkg::VERDICT_BLOCKED && blocked_r)
    else $error("blocked mode entered without a now-blocked result");

  a_unblock_reload: assert property (@(posedge clk) disable iff (rst)
    $fell(blocked_mode) |-> verdict_r == kcl_pkg::VERDICT_UNBLOCKED
                            && attempts_remaining == kcl_pkg::granted(max_attempts))
    else $error("unblock without full attempt reload");

endmodule
